FILE: hw/rtl/rgbhsv_pkg.sv
// Shared types and constants of the RGB to HSV converter.
// No dependencies; every other file of the block refers to it by scoped names.
package rgbhsv_pkg;

	localparam int unsigned PIX_W    = 8;   // one color component
	localparam int unsigned HUE_W    = 15;  // hue in 1/64 degree
	localparam int unsigned SAT_W    = 17;  // saturation, Q1.16
	localparam int unsigned SAT_FRAC = 16;
	localparam int unsigned REM_W    = 24;  // partial remainder of either divide
	localparam int unsigned QUO_W    = 17;  // quotient bits, one cell per bit

	// 60 degrees in 1/64 degree units
	localparam logic [REM_W-1:0] HUE_SECTOR = REM_W'(3840);

	// One long-division lane: remainder, divisor, quotient so far, forced-zero flag
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [PIX_W-1:0] div;
		logic [QUO_W-1:0] quo;
		logic             zero;
	} div_lane_t;

	// Everything one item carries down the cell row
	typedef struct packed {
		div_lane_t hue;
		div_lane_t sat;   // sat.div is the largest component, i.e. value
	} div_item_t;

endpackage

FILE: hw/rtl/rgbhsv_front.sv
// Front stage: max, min, delta, hue sector and the two dividends of one pixel.
// Depends on rgbhsv_pkg.
module rgbhsv_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             up_valid,
	input  logic [rgbhsv_pkg::PIX_W-1:0]     red,
	input  logic [rgbhsv_pkg::PIX_W-1:0]     green,
	input  logic [rgbhsv_pkg::PIX_W-1:0]     blue,
	output logic                             dn_valid,
	output rgbhsv_pkg::div_item_t            dn_data
);

	logic [rgbhsv_pkg::PIX_W-1:0] mx, mn, delta;
	logic signed [11:0]           n_s, base_s, t_s;
	logic [10:0]                  t_u;
	rgbhsv_pkg::div_item_t        item;
	logic                         valid_s1;
	rgbhsv_pkg::div_item_t        data_s1;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		delta = mx - mn;

		// sector priority: red, then green, then blue
		if (mx == red) begin
			n_s    = $signed({4'b0, green}) - $signed({4'b0, blue});
			base_s = n_s < 0 ? $signed(12'(delta) * 12'd6) : 12'sd0;
		end else if (mx == green) begin
			n_s    = $signed({4'b0, blue}) - $signed({4'b0, red});
			base_s = $signed(12'(delta) * 12'd2);
		end else begin
			n_s    = $signed({4'b0, red}) - $signed({4'b0, green});
			base_s = $signed(12'(delta) * 12'd4);
		end
		t_s = n_s + base_s;   // in [0, 6*delta)
		t_u = t_s[10:0];

		item.hue.rem  = {13'b0, t_u} * rgbhsv_pkg::HUE_SECTOR;
		item.hue.div  = delta;
		item.hue.quo  = '0;
		item.hue.zero = (delta == '0);
		item.sat.rem  = {delta, {rgbhsv_pkg::SAT_FRAC{1'b0}}};
		item.sat.div  = mx;
		item.sat.quo  = '0;
		item.sat.zero = (mx == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= item;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

FILE: hw/rtl/rgbhsv_cell.sv
// One cell of the divider row: settles quotient bit BIT of both the hue and
// the saturation divide and hands the item on. Depends on rgbhsv_pkg.
module rgbhsv_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  up_valid,
	input  rgbhsv_pkg::div_item_t up_data,
	output logic                  dn_valid,
	output rgbhsv_pkg::div_item_t dn_data
);

	localparam logic [rgbhsv_pkg::QUO_W-1:0] QBIT = rgbhsv_pkg::QUO_W'(1) << BIT;

	function automatic rgbhsv_pkg::div_lane_t div_step(rgbhsv_pkg::div_lane_t l);
		logic [rgbhsv_pkg::REM_W-1:0] dsh;
		rgbhsv_pkg::div_lane_t        r;
		dsh = {{(rgbhsv_pkg::REM_W - rgbhsv_pkg::PIX_W){1'b0}}, l.div} << BIT;
		r   = l;
		if (l.rem >= dsh) begin
			r.rem = l.rem - dsh;
			r.quo = l.quo | QBIT;
		end
		return r;
	endfunction

	rgbhsv_pkg::div_item_t nxt;
	logic                  valid_q;
	rgbhsv_pkg::div_item_t data_q;

	always_comb begin
		nxt.hue = div_step(up_data.hue);
		nxt.sat = div_step(up_data.sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

FILE: hw/rtl/rgbhsv_round.sv
// Output stage: rounds both quotients to nearest (halves up), forces the
// grey and black cases to zero and holds the result item. Depends on rgbhsv_pkg.
module rgbhsv_round (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          up_valid,
	input  rgbhsv_pkg::div_item_t         up_data,
	output logic                          out_valid,
	output logic [rgbhsv_pkg::HUE_W-1:0]  hue,
	output logic [rgbhsv_pkg::SAT_W-1:0]  saturation,
	output logic [rgbhsv_pkg::PIX_W-1:0]  value
);

	logic                            hue_up, sat_up;
	logic [rgbhsv_pkg::QUO_W-1:0]    hue_sum, sat_sum;
	logic                            valid_q;
	logic [rgbhsv_pkg::HUE_W-1:0]    hue_q;
	logic [rgbhsv_pkg::SAT_W-1:0]    sat_q;
	logic [rgbhsv_pkg::PIX_W-1:0]    value_q;

	// remainder is below the divisor here, so its low byte is all of it
	always_comb begin
		hue_up  = {up_data.hue.rem[rgbhsv_pkg::PIX_W-1:0], 1'b0} >= {1'b0, up_data.hue.div};
		sat_up  = {up_data.sat.rem[rgbhsv_pkg::PIX_W-1:0], 1'b0} >= {1'b0, up_data.sat.div};
		hue_sum = up_data.hue.quo + rgbhsv_pkg::QUO_W'(hue_up);
		sat_sum = up_data.sat.quo + rgbhsv_pkg::QUO_W'(sat_up);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q   <= up_data.hue.zero ? '0 : hue_sum[rgbhsv_pkg::HUE_W-1:0];
			sat_q   <= up_data.sat.zero ? '0 : sat_sum[rgbhsv_pkg::SAT_W-1:0];
			value_q <= up_data.sat.div;
		end
	end

	assign out_valid  = valid_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign value      = value_q;

endmodule

FILE: hw/rtl/rgb_to_hsv_convert.sv
// Top level of the RGB to HSV converter: front stage, a row of divider cells
// (one per quotient bit) and the rounding output stage. Depends on rgbhsv_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_ready  | red_in, green_in, blue_in (8b each)
//   out     | out_valid / out_ready| hue_out (15b), saturation_out (17b),
//           |                      | value_out (8b)
//
// One item per cycle unless out_ready stalls; stages: front stage, 17 divider
// cells (one quotient bit each, both divides side by side), output stage.
// Reset clears only the valid bits of the stages; nothing else needs clearing.
// A stall on out_ready freezes the whole row; in_ready is low only while a
// result waits in the output register and out_ready is low.
module rgb_to_hsv_convert (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rgbhsv_pkg::PIX_W-1:0]  red_in,
	input  logic [rgbhsv_pkg::PIX_W-1:0]  green_in,
	input  logic [rgbhsv_pkg::PIX_W-1:0]  blue_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rgbhsv_pkg::HUE_W-1:0]  hue_out,
	output logic [rgbhsv_pkg::SAT_W-1:0]  saturation_out,
	output logic [rgbhsv_pkg::PIX_W-1:0]  value_out
);

	localparam int unsigned NCELL = rgbhsv_pkg::QUO_W;

	logic                  en;
	logic                  stage_valid [NCELL+1];
	rgbhsv_pkg::div_item_t stage_data  [NCELL+1];

	// advance the row whenever the output register is free or being taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	rgbhsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.up_valid (in_valid),
		.red      (red_in),
		.green    (green_in),
		.blue     (blue_in),
		.dn_valid (stage_valid[0]),
		.dn_data  (stage_data[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		rgbhsv_cell #(
			.BIT (NCELL - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (stage_valid[i]),
			.up_data  (stage_data[i]),
			.dn_valid (stage_valid[i+1]),
			.dn_data  (stage_data[i+1])
		);
	end

	rgbhsv_round u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.up_valid   (stage_valid[NCELL]),
		.up_data    (stage_data[NCELL]),
		.out_valid  (out_valid),
		.hue        (hue_out),
		.saturation (saturation_out),
		.value      (value_out)
	);

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue_out < rgbhsv_pkg::HUE_W'(23040))
		else $error("hue beyond full turn");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> saturation_out <= rgbhsv_pkg::SAT_W'(65536))
		else $error("saturation above one");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_out == '0 |-> saturation_out == '0 && hue_out == '0)
		else $error("black pixel with nonzero hue or saturation");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturation_out == '0 |-> hue_out == '0)
		else $error("grey pixel with nonzero hue");

endmodule

FILE: dv/rgb_to_hsv_convert_checker.sv
// Checker for the RGB to HSV converter: watches both channels, predicts each
// result from the accepted pixel and compares it field by field.
// Depends on rgbhsv_pkg for the field widths.
module rgb_to_hsv_convert_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [rgbhsv_pkg::PIX_W-1:0]  red_in,
	input  logic [rgbhsv_pkg::PIX_W-1:0]  green_in,
	input  logic [rgbhsv_pkg::PIX_W-1:0]  blue_in,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [rgbhsv_pkg::HUE_W-1:0]  hue_out,
	input  logic [rgbhsv_pkg::SAT_W-1:0]  saturation_out,
	input  logic [rgbhsv_pkg::PIX_W-1:0]  value_out,
	output int                            mismatches,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SECTOR    = 3840;   // 60 degrees in 1/64 degree
	localparam int FULL_TURN = 23040;  // 360 degrees in 1/64 degree
	localparam int SAT_ONE   = 65536;  // 1.0 in Q1.16

	typedef struct packed {
		logic [rgbhsv_pkg::HUE_W-1:0] hue;
		logic [rgbhsv_pkg::SAT_W-1:0] sat;
		logic [rgbhsv_pkg::PIX_W-1:0] val;
	} hsv_t;

	hsv_t hsv_expected_q[$];
	int   pixels_seen = 0;

	function automatic hsv_t pixel_to_hsv(logic [rgbhsv_pkg::PIX_W-1:0] r,
			logic [rgbhsv_pkg::PIX_W-1:0] g, logic [rgbhsv_pkg::PIX_W-1:0] b);
		int   rr, gg, bb, top, bottom, delta, numer;
		hsv_t res;
		rr = int'(r);
		gg = int'(g);
		bb = int'(b);
		top = rr;
		if (gg > top) top = gg;
		if (bb > top) top = bb;
		bottom = rr;
		if (gg < bottom) bottom = gg;
		if (bb < bottom) bottom = bb;
		delta = top - bottom;
		res.val = rgbhsv_pkg::PIX_W'(top);
		if (delta == 0) begin
			res.hue = '0;
		end else begin
			// sector priority on ties: red, then green, then blue
			if (top == rr) begin
				numer = SECTOR * (gg - bb);
				if (numer < 0) numer += FULL_TURN * delta;
			end else if (top == gg) begin
				numer = SECTOR * (bb - rr) + 2 * SECTOR * delta;
			end else begin
				numer = SECTOR * (rr - gg) + 4 * SECTOR * delta;
			end
			res.hue = rgbhsv_pkg::HUE_W'((2 * numer + delta) / (2 * delta));
		end
		if (top == 0)
			res.sat = '0;
		else
			res.sat = rgbhsv_pkg::SAT_W'((2 * delta * SAT_ONE + top) / (2 * top));
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t ns: mismatch in %s: got %0d, expected %0d (result %0d)",
			$time, what, got, want, pixels_seen);
		mismatches++;
	endtask

	always @(posedge clk) begin
		hsv_t want;
		if (!arst_n) begin
			mismatches = 0;
			pending    = 0;
		end else begin
			// check the result before taking a new pixel, so a stray result stays visible
			if (out_valid && out_ready) begin
				if (hsv_expected_q.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = hsv_expected_q.pop_front();
					if (hue_out !== want.hue)
						report_mismatch("hue", int'(hue_out), int'(want.hue));
					if (saturation_out !== want.sat)
						report_mismatch("saturation", int'(saturation_out), int'(want.sat));
					if (value_out !== want.val)
						report_mismatch("value", int'(value_out), int'(want.val));
				end
				pixels_seen++;
			end
			if (in_valid && in_ready)
				hsv_expected_q.push_back(pixel_to_hsv(red_in, green_in, blue_in));
			pending = hsv_expected_q.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
// Top of the RGB to HSV converter testbench: clock, reset, pixel stimulus and
// output back-pressure, plus the verdict. Depends on rgbhsv_pkg, the converter
// and rgb_to_hsv_convert_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 25;   // a little over the pipeline latency
	localparam int HOLD_CYCLES  = 80;   // long receiver stall, deeper than the pipe
	localparam int RANDOM_ITEMS = 650;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [rgbhsv_pkg::PIX_W-1:0] red_in = '0;
	logic [rgbhsv_pkg::PIX_W-1:0] green_in = '0;
	logic [rgbhsv_pkg::PIX_W-1:0] blue_in = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [rgbhsv_pkg::HUE_W-1:0] hue_out;
	logic [rgbhsv_pkg::SAT_W-1:0] saturation_out;
	logic [rgbhsv_pkg::PIX_W-1:0] value_out;

	int mismatches;
	int pending;
	int send_idle_pct = 12;
	int recv_idle_pct = 70;
	bit long_hold = 1'b0;
	int hold_count = 0;

	always #4 clk = ~clk;

	rgb_to_hsv_convert dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.red_in         (red_in),
		.green_in       (green_in),
		.blue_in        (blue_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hue_out        (hue_out),
		.saturation_out (saturation_out),
		.value_out      (value_out)
	);

	rgb_to_hsv_convert_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.red_in         (red_in),
		.green_in       (green_in),
		.blue_in        (blue_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hue_out        (hue_out),
		.saturation_out (saturation_out),
		.value_out      (value_out),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	// receiver: random back-pressure, one long stall when asked
	always @(negedge clk) begin
		if (long_hold && hold_count < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			hold_count++;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// call just after a falling edge; returns just after a falling edge
	task automatic send_pixel(logic [rgbhsv_pkg::PIX_W-1:0] r,
			logic [rgbhsv_pkg::PIX_W-1:0] g, logic [rgbhsv_pkg::PIX_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic send_random_pixel();
		logic [rgbhsv_pkg::PIX_W-1:0] r, g, b, base;
		int                           kind;
		kind = $urandom_range(99);
		r = rgbhsv_pkg::PIX_W'($urandom);
		g = rgbhsv_pkg::PIX_W'($urandom);
		b = rgbhsv_pkg::PIX_W'($urandom);
		base = rgbhsv_pkg::PIX_W'($urandom);
		if (kind < 50) begin
			// fully random pixel
		end else if (kind < 60) begin
			r = base; g = base; b = base;          // grey or black
		end else if (kind < 75) begin
			// two components made equal, which may tie for the largest
			case ($urandom_range(2))
				0: g = r;
				1: b = g;
				default: b = r;
			endcase
		end else if (kind < 90) begin
			// small delta, hue and saturation rounding near their edges
			r = base;
			g = base - rgbhsv_pkg::PIX_W'($urandom_range(2));
			b = base - rgbhsv_pkg::PIX_W'($urandom_range(2));
			if ($urandom_range(1)) begin
				r = g;
				g = base;
			end
		end else begin
			// extremes of each component
			r = $urandom_range(1) ? 8'hFF : rgbhsv_pkg::PIX_W'($urandom_range(1));
			g = $urandom_range(1) ? 8'hFF : rgbhsv_pkg::PIX_W'($urandom_range(1));
			b = $urandom_range(1) ? 8'hFF : rgbhsv_pkg::PIX_W'($urandom_range(1));
		end
		send_pixel(r, g, b);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed pixels: black, greys, primaries, ties, hue wrap, tiny values
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd254);
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd255);
		send_pixel(8'd255, 8'd1,   8'd0);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd1,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd1,   8'd0,   8'd1);
		send_pixel(8'd1,   8'd1,   8'd0);
		send_pixel(8'd0,   8'd1,   8'd1);
		send_pixel(8'd1,   8'd0,   8'd255);
		send_pixel(8'd254, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd128, 8'd255);
		send_pixel(8'd170, 8'd85,  8'd0);

		repeat (RANDOM_ITEMS / 3) send_random_pixel();

		// swap idle rates after the pipe has emptied
		wait_drained();
		send_idle_pct = 70;
		recv_idle_pct = 12;
		repeat (RANDOM_ITEMS / 3) send_random_pixel();

		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// fill the pipe against a long receiver stall until the input backs up
		long_hold = 1'b1;
		repeat (60) send_random_pixel();
		repeat (RANDOM_ITEMS / 3 - 60) send_random_pixel();

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
